// ----- sv/bgcd_pkg.sv -----
package bgcd_pkg;

    localparam int DATA_W    = 32;
    localparam int WIDTH_DEF = 32;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_TWOS,
        ST_REDUCE,
        ST_FINISH
    } t_state;

    typedef enum logic [3:0] {
        OP_HOLD,
        OP_LOAD,
        OP_TAKE_A,
        OP_HALVE_BOTH,
        OP_HALVE_A,
        OP_HALVE_B,
        OP_SUB_A,
        OP_SUB_B,
        OP_RESULT
    } t_dp_op;

    typedef struct packed {
        logic a_zero;
        logic b_zero;
        logic a_odd;
        logic b_odd;
        logic a_ge_b;
    } t_dp_status;

endpackage

// ----- sv/binary_gcd_top.sv -----
// Binary (Stein) gcd of two unsigned operands, low WIDTH bits of each used.
// Raise start with the operands while busy is low; the pair is taken at that
// edge and busy stays high until the result is ready. The result appears on
// o_gcd_value as o_valid pulses high for exactly one cycle; there is no way to
// stall it, so capture it in that cycle. One shared subtract/shift datapath
// does one halving or one subtract-and-halve per cycle, and a pair finishes
// sooner for operands with small values or many factors of two. A zero
// second operand returns the first operand; two zero operands return zero.
// A new pair may be started in the cycle o_valid is high.
module binary_gcd_top #(
    parameter int WIDTH = bgcd_pkg::WIDTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    input  logic [bgcd_pkg::DATA_W-1:0] i_operand_a,
    input  logic [bgcd_pkg::DATA_W-1:0] i_operand_b,
    output logic                        busy,
    output logic                        o_valid,
    output logic [bgcd_pkg::DATA_W-1:0] o_gcd_value
);
    import bgcd_pkg::*;

    t_dp_op     dp_op;
    t_dp_status dp_status;

    bgcd_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_status (dp_status),
        .o_op     (dp_op),
        .busy     (busy),
        .o_valid  (o_valid)
    );

    bgcd_dp #(
        .WIDTH (WIDTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_op        (dp_op),
        .i_operand_a (i_operand_a),
        .i_operand_b (i_operand_b),
        .o_status    (dp_status),
        .o_gcd_value (o_gcd_value)
    );

endmodule

// ----- sv/bgcd_ctrl.sv -----
module bgcd_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    input  bgcd_pkg::t_dp_status i_status,
    output bgcd_pkg::t_dp_op   o_op,
    output logic               busy,
    output logic               o_valid
);
    import bgcd_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   r_valid;
    logic   n_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_state = ST_TWOS;
                end
            end
            ST_TWOS: begin
                if (i_status.b_zero) begin
                    n_state = ST_FINISH;
                end else if (i_status.a_odd || i_status.b_odd) begin
                    n_state = ST_REDUCE;
                end
            end
            ST_REDUCE: begin
                if (i_status.b_odd && i_status.a_zero) begin
                    n_state = ST_FINISH;
                end
            end
            ST_FINISH: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_op    = OP_HOLD;
        n_valid = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (start) begin
                    o_op = OP_LOAD;
                end
            end
            ST_TWOS: begin
                if (i_status.b_zero) begin
                    o_op = OP_TAKE_A;
                end else if (!i_status.a_odd && !i_status.b_odd) begin
                    o_op = OP_HALVE_BOTH;
                end
            end
            ST_REDUCE: begin
                // strip b first so a zero a still leaves an odd b
                if (!i_status.b_odd) begin
                    o_op = OP_HALVE_B;
                end else if (i_status.a_zero) begin
                    o_op = OP_HOLD;
                end else if (!i_status.a_odd) begin
                    o_op = OP_HALVE_A;
                end else if (i_status.a_ge_b) begin
                    o_op = OP_SUB_A;
                end else begin
                    o_op = OP_SUB_B;
                end
            end
            ST_FINISH: begin
                o_op    = OP_RESULT;
                n_valid = 1'b1;
            end
            default: begin
                o_op = OP_HOLD;
            end
        endcase
    end

    assign busy    = (r_state != ST_IDLE);
    assign o_valid = r_valid;

endmodule

// ----- sv/bgcd_dp.sv -----
module bgcd_dp #(
    parameter int WIDTH = bgcd_pkg::WIDTH_DEF
) (
    input  logic                          i_clk,
    input  bgcd_pkg::t_dp_op              i_op,
    input  logic [bgcd_pkg::DATA_W-1:0]   i_operand_a,
    input  logic [bgcd_pkg::DATA_W-1:0]   i_operand_b,
    output bgcd_pkg::t_dp_status          o_status,
    output logic [bgcd_pkg::DATA_W-1:0]   o_gcd_value
);
    import bgcd_pkg::*;

    localparam int KW = $clog2(WIDTH);

    logic [WIDTH-1:0]        r_a;
    logic [WIDTH-1:0]        r_b;
    logic [KW-1:0]           r_k;
    logic [WIDTH-1:0]        r_result;
    logic [WIDTH+DATA_W-1:0] ext_a;
    logic [WIDTH+DATA_W-1:0] ext_b;
    logic [WIDTH+DATA_W-1:0] ext_res;
    logic [WIDTH:0]          a_minus_b;
    logic [WIDTH-1:0]        b_minus_a;

    assign ext_a     = {{WIDTH{1'b0}}, i_operand_a};
    assign ext_b     = {{WIDTH{1'b0}}, i_operand_b};
    assign a_minus_b = {1'b0, r_a} - {1'b0, r_b};
    assign b_minus_a = r_b - r_a;

    always_ff @(posedge i_clk) begin
        case (i_op)
            OP_LOAD: begin
                r_a <= ext_a[WIDTH-1:0];
                r_b <= ext_b[WIDTH-1:0];
                r_k <= '0;
            end
            OP_TAKE_A: begin
                r_b <= r_a;
                r_a <= '0;
            end
            OP_HALVE_BOTH: begin
                r_a <= r_a >> 1;
                r_b <= r_b >> 1;
                r_k <= r_k + KW'(1);
            end
            OP_HALVE_A: begin
                r_a <= r_a >> 1;
            end
            OP_HALVE_B: begin
                r_b <= r_b >> 1;
            end
            OP_SUB_A: begin
                r_a <= a_minus_b[WIDTH:1];
            end
            OP_SUB_B: begin
                r_b <= b_minus_a >> 1;
            end
            OP_RESULT: begin
                r_result <= r_b << r_k;
            end
            default: begin
            end
        endcase
    end

    assign o_status.a_zero = (r_a == '0);
    assign o_status.b_zero = (r_b == '0);
    assign o_status.a_odd  = r_a[0];
    assign o_status.b_odd  = r_b[0];
    assign o_status.a_ge_b = !a_minus_b[WIDTH];

    assign ext_res     = {{DATA_W{1'b0}}, r_result};
    assign o_gcd_value = ext_res[DATA_W-1:0];

endmodule
